// File: rtl/fpdr_pkg.sv
package fpdr_pkg;

	// Posture codes
	localparam logic [2:0] P_BALANCE   = 3'd0;
	localparam logic [2:0] P_LEFTFALL  = 3'd1;
	localparam logic [2:0] P_RIGHTFALL = 3'd2;
	localparam logic [2:0] P_DIVED     = 3'd3;
	localparam logic [2:0] P_LIED      = 3'd4;
	localparam logic [2:0] P_DIVING    = 3'd5;
	localparam logic [2:0] P_LYING     = 3'd6;

	// Recovery request codes
	localparam logic [2:0] REQ_NONE          = 3'd0;
	localparam logic [2:0] REQ_LEFT_TO_LIE   = 3'd1;
	localparam logic [2:0] REQ_LEFT_TO_DIVE  = 3'd2;
	localparam logic [2:0] REQ_RIGHT_TO_LIE  = 3'd3;
	localparam logic [2:0] REQ_RIGHT_TO_DIVE = 3'd4;
	localparam logic [2:0] REQ_UP_FROM_LIE   = 3'd5;
	localparam logic [2:0] REQ_UP_FROM_DIVE  = 3'd6;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_MS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECOVER_MS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MODE_SWAP_MS    = 2'd3;
	localparam int unsigned CFG_DATA_W = 16;

	// Reset values: 9.0 m/s2 in Q8.8, 0.09 s, 0.3 s, 2.0 s
	localparam logic signed [15:0] ACCEL_THRESHOLD_RST = 16'sd2304;
	localparam logic [15:0]        SETTLE_MS_RST       = 16'd90;
	localparam logic [15:0]        RECOVER_MS_RST      = 16'd300;
	localparam logic [15:0]        MODE_SWAP_MS_RST    = 16'd2000;

	localparam logic [15:0] UNBAL_MAX = 16'hFFFF;

	typedef struct packed {
		logic               left_fall;
		logic               right_fall;
		logic               dived_flag;
		logic               lied_flag;
		logic               diving_flag;
		logic               lying_flag;
		logic signed [15:0] accel_z;
		logic [31:0]        now_ms;
		logic               task_idle;
		logic [15:0]        task_duration_ms;
	} in_t;

	typedef struct packed {
		logic [2:0]  posture;
		logic [2:0]  candidate;
		logic [15:0] unbalance_ticks;
		logic [2:0]  recovery_request;
	} out_t;

endpackage

// File: rtl/fall_posture_debounce_recovery.sv
// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+--------------------------
// in       | input     | in_valid / in_ready   | in_data  (fpdr_pkg::in_t)
// out      | output    | out_valid / out_ready | out_data (fpdr_pkg::out_t)
// cfg      | input     | cfg_we                | cfg_index, cfg_wdata
//
// One request per cycle sustained while out_ready stays high.
// A request is registered, then the posture logic runs in one pass into the result register,
// updating the tracking state in the same edge.
// arst_n clears control state, tracking state and configuration to their defaults.
// A stalled result holds the input register; in_ready stays high while the input register
// is empty or moving forward.
module fall_posture_debounce_recovery (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  fpdr_pkg::in_t                         in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output fpdr_pkg::out_t                        out_data,
	input  logic                                  cfg_we,
	input  logic [fpdr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [fpdr_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import fpdr_pkg::*;

	// Configuration registers
	logic signed [15:0] accel_threshold_q;
	logic [15:0]        settle_ms_q;
	logic [15:0]        recover_ms_q;
	logic [15:0]        mode_swap_ms_q;

	// Tracking state
	logic [2:0]  posture_q;
	logic [2:0]  last_cand_q;
	logic [31:0] hold_start_q;
	logic [15:0] unbal_q;
	logic        prefer_dive_q;

	// Pipeline
	logic  valid_s1;
	in_t   req_s1;
	logic  out_valid_q;
	out_t  out_data_q;
	logic  advance;

	// Next-state values
	logic [2:0]  cand;
	logic [15:0] unbal_next;
	logic [31:0] hold_start_next;
	logic [31:0] held_ms;
	logic [2:0]  posture_next;
	logic        prefer_next;
	logic [2:0]  rec_req;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_threshold_q <= ACCEL_THRESHOLD_RST;
			settle_ms_q       <= SETTLE_MS_RST;
			recover_ms_q      <= RECOVER_MS_RST;
			mode_swap_ms_q    <= MODE_SWAP_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACCEL_THRESHOLD: accel_threshold_q <= $signed(cfg_wdata);
				CFG_SETTLE_MS:       settle_ms_q       <= cfg_wdata;
				CFG_RECOVER_MS:      recover_ms_q      <= cfg_wdata;
				CFG_MODE_SWAP_MS:    mode_swap_ms_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Candidate: priority encode, then acceleration override
	always_comb begin
		if (req_s1.left_fall)        cand = P_LEFTFALL;
		else if (req_s1.right_fall)  cand = P_RIGHTFALL;
		else if (req_s1.dived_flag)  cand = P_DIVED;
		else if (req_s1.lied_flag)   cand = P_LIED;
		else if (req_s1.diving_flag) cand = P_DIVING;
		else if (req_s1.lying_flag)  cand = P_LYING;
		else if (last_cand_q == P_DIVED || last_cand_q == P_LIED ||
				last_cand_q == P_BALANCE)
			cand = P_BALANCE;
		else
			cand = last_cand_q;
		if (req_s1.accel_z > accel_threshold_q) cand = P_BALANCE;
	end

	// Counter, debounce and preference
	always_comb begin
		if (cand == P_BALANCE)       unbal_next = '0;
		else if (unbal_q == UNBAL_MAX) unbal_next = unbal_q;
		else                         unbal_next = unbal_q + 16'd1;

		hold_start_next = (cand != last_cand_q) ? req_s1.now_ms : hold_start_q;
		held_ms         = req_s1.now_ms - hold_start_next;
		posture_next    = (held_ms > {16'd0, settle_ms_q}) ? cand : posture_q;

		prefer_next = prefer_dive_q;
		if (req_s1.task_idle && (req_s1.task_duration_ms > mode_swap_ms_q))
			prefer_next = !prefer_dive_q;
	end

	// Recovery request selection
	always_comb begin
		rec_req = REQ_NONE;
		if (req_s1.task_idle && (held_ms > {16'd0, recover_ms_q})) begin
			case (posture_next)
				P_LEFTFALL:  rec_req = prefer_next ? REQ_LEFT_TO_DIVE : REQ_LEFT_TO_LIE;
				P_RIGHTFALL: rec_req = prefer_next ? REQ_RIGHT_TO_DIVE : REQ_RIGHT_TO_LIE;
				P_LIED:      rec_req = REQ_UP_FROM_LIE;
				P_DIVED:     rec_req = REQ_UP_FROM_DIVE;
				default:     rec_req = REQ_NONE;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) req_s1 <= in_data;
	end

	// Tracking state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			posture_q     <= P_BALANCE;
			last_cand_q   <= P_BALANCE;
			hold_start_q  <= '0;
			unbal_q       <= '0;
			prefer_dive_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				posture_q     <= posture_next;
				last_cand_q   <= cand;
				hold_start_q  <= hold_start_next;
				unbal_q       <= unbal_next;
				prefer_dive_q <= prefer_next;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.posture          <= posture_next;
			out_data_q.candidate        <= cand;
			out_data_q.unbalance_ticks  <= unbal_next;
			out_data_q.recovery_request <= rec_req;
		end
	end

	// Balance candidate always shows a cleared counter
	a_unbal_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.candidate == P_BALANCE |-> out_data.unbalance_ticks == 16'd0)
		else $error("unbalance count not cleared on balance candidate");

	// Requests only for fallen, dived or lied postures
	a_req_posture: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.recovery_request != REQ_NONE |->
		(out_data.posture == P_LEFTFALL || out_data.posture == P_RIGHTFALL ||
		 out_data.posture == P_DIVED || out_data.posture == P_LIED))
		else $error("recovery request for a posture without recovery");

	// Tracked candidate, counter and posture match the result just produced
	a_last_cand: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid && last_cand_q == out_data.candidate && unbal_q ==
		out_data.unbalance_ticks && posture_q == out_data.posture)
		else $error("tracking state out of step with result");

	// Empty output stage never blocks input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output stage");

endmodule

// File: verif/fall_posture_debounce_recovery_test.sv
module fall_posture_debounce_recovery_test;
	timeunit 1ns;
	timeprecision 1ps;

	import fpdr_pkg::*;

	// Tracks posture, debounce and recovery state, and holds the results still owed
	class fall_tracker;
		logic signed [15:0] accel_thr;
		logic [15:0]        settle_ms;
		logic [15:0]        recover_ms;
		logic [15:0]        swap_ms;
		logic [2:0]         cur_posture;
		logic [2:0]         last_cand;
		logic [31:0]        hold_start;
		logic [15:0]        unbal_cnt;
		bit                 prefer_dive;
		out_t               posture_reports[$];
		int                 errors;

		function new();
			accel_thr   = ACCEL_THRESHOLD_RST;
			settle_ms   = SETTLE_MS_RST;
			recover_ms  = RECOVER_MS_RST;
			swap_ms     = MODE_SWAP_MS_RST;
			cur_posture = P_BALANCE;
			last_cand   = P_BALANCE;
			hold_start  = '0;
			unbal_cnt   = '0;
			prefer_dive = 1'b0;
			errors      = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_ACCEL_THRESHOLD: accel_thr  = data;
				CFG_SETTLE_MS:       settle_ms  = data;
				CFG_RECOVER_MS:      recover_ms = data;
				CFG_MODE_SWAP_MS:    swap_ms    = data;
				default: ;
			endcase
		endfunction

		// One accepted tick: advance the state and queue the result it owes
		function void note_tick(in_t r);
			logic [2:0]  cand;
			logic [2:0]  req;
			logic [31:0] held;
			out_t        e;
			if (r.left_fall)        cand = P_LEFTFALL;
			else if (r.right_fall)  cand = P_RIGHTFALL;
			else if (r.dived_flag)  cand = P_DIVED;
			else if (r.lied_flag)   cand = P_LIED;
			else if (r.diving_flag) cand = P_DIVING;
			else if (r.lying_flag)  cand = P_LYING;
			else if (last_cand == P_BALANCE || last_cand == P_DIVED || last_cand == P_LIED)
				cand = P_BALANCE;
			else
				cand = last_cand;

			// strong upward push means the robot is standing
			if ($signed(r.accel_z) > accel_thr) cand = P_BALANCE;

			if (cand == P_BALANCE) unbal_cnt = '0;
			else if (unbal_cnt != UNBAL_MAX) unbal_cnt = unbal_cnt + 16'd1;

			if (cand != last_cand) hold_start = r.now_ms;
			last_cand = cand;
			held = r.now_ms - hold_start;
			if (held > 32'(settle_ms)) cur_posture = cand;

			// preference flips first, so the request sees the new one
			req = REQ_NONE;
			if (r.task_idle) begin
				if (r.task_duration_ms > swap_ms) prefer_dive = !prefer_dive;
				if (held > 32'(recover_ms)) begin
					case (cur_posture)
						P_LEFTFALL:  req = prefer_dive ? REQ_LEFT_TO_DIVE : REQ_LEFT_TO_LIE;
						P_RIGHTFALL: req = prefer_dive ? REQ_RIGHT_TO_DIVE : REQ_RIGHT_TO_LIE;
						P_LIED:      req = REQ_UP_FROM_LIE;
						P_DIVED:     req = REQ_UP_FROM_DIVE;
						default:     req = REQ_NONE;
					endcase
				end
			end

			e.posture          = cur_posture;
			e.candidate        = cand;
			e.unbalance_ticks  = unbal_cnt;
			e.recovery_request = req;
			posture_reports = {posture_reports, e};
		endfunction

		function void check_report(out_t got);
			out_t e;
			if (posture_reports.size() == 0) begin
				$error("result with nothing pending: %p", got);
				errors++;
				return;
			end
			e = posture_reports.pop_front();
			if (got.posture !== e.posture) begin
				$error("posture: expected %0d, got %0d", e.posture, got.posture);
				errors++;
			end
			if (got.candidate !== e.candidate) begin
				$error("candidate: expected %0d, got %0d", e.candidate, got.candidate);
				errors++;
			end
			if (got.unbalance_ticks !== e.unbalance_ticks) begin
				$error("unbalance_ticks: expected %0d, got %0d",
					e.unbalance_ticks, got.unbalance_ticks);
				errors++;
			end
			if (got.recovery_request !== e.recovery_request) begin
				$error("recovery_request: expected %0d, got %0d",
					e.recovery_request, got.recovery_request);
				errors++;
			end
		endfunction

		function int pending();
			return posture_reports.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_t                   in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_t                  out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	fall_tracker tracker;
	bit          quiet;      // no idling on either side
	int          out_hold;   // receiver hold-off, in cycles
	logic [31:0] clock_ms;

	fall_posture_debounce_recovery u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("fall_posture_debounce_recovery_test: FAIL");
		$finish;
	end

	// Sample all handshakes on the edge they complete
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) tracker.set_register(cfg_index, cfg_wdata);
			if (in_valid && in_ready) tracker.note_tick(in_data);
			if (out_valid && out_ready) tracker.check_report(out_data);
		end
	end

	// Receiver: random stalls, or a counted hold-off when asked
	initial begin
		forever begin
			@(posedge clk);
			if (out_hold > 0) begin
				out_ready <= 1'b0;
				out_hold--;
			end else begin
				out_ready <= quiet || ($urandom_range(99) >= 6);
			end
		end
	end

	function automatic in_t tick(logic [5:0] flags, logic [15:0] az, logic [31:0] now,
		bit idle, logic [15:0] dur);
		in_t r;
		r = '0;
		{r.left_fall, r.right_fall, r.dived_flag, r.lied_flag, r.diving_flag,
			r.lying_flag} = flags;
		r.accel_z          = az;
		r.now_ms           = now;
		r.task_idle        = idle;
		r.task_duration_ms = dur;
		return r;
	endfunction

	// Called on a clock edge; returns on the edge the request is taken
	task automatic offer_tick(in_t r);
		if (!quiet && $urandom_range(99) < 6) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_reports();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_limits(logic [15:0] thr, logic [15:0] settle, logic [15:0] rec,
		logic [15:0] swap);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ACCEL_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_index <= CFG_SETTLE_MS;
		cfg_wdata <= settle;
		@(posedge clk);
		cfg_index <= CFG_RECOVER_MS;
		cfg_wdata <= rec;
		@(posedge clk);
		cfg_index <= CFG_MODE_SWAP_MS;
		cfg_wdata <= swap;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Episodes of a held flag pattern with time moving in control ticks
	task automatic run_falls(int n);
		int          done;
		int          len;
		int          sel;
		int          k;
		logic [5:0]  flags;
		logic [5:0]  fl;
		logic [31:0] dt;
		logic [15:0] az;
		logic [15:0] dur;
		done = 0;
		while (done < n) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) flags = 6'b1 << sel;
			else if (sel < 8) flags = 6'($urandom);
			else flags = '0;
			len = $urandom_range(1, 30);
			for (k = 0; k < len && done < n; k++) begin
				fl  = ($urandom_range(99) < 8) ? 6'($urandom) : flags;
				sel = $urandom_range(99);
				dt  = (sel < 85) ? 32'd20 : (sel < 97) ? 32'($urandom_range(0, 400)) : $urandom;
				clock_ms = clock_ms + dt;
				az  = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 5000)) - 16'd2000
					: 16'($urandom);
				dur = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
				offer_tick(tick(fl, az, clock_ms, 1'($urandom), dur));
				done++;
			end
		end
	endtask

	initial begin
		tracker   = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		out_ready = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_ACCEL_THRESHOLD;
		cfg_wdata = '0;
		quiet     = 1'b0;
		out_hold  = 0;
		clock_ms  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: priority, each posture's request, forced balance, time wrap
		offer_tick(tick(6'b000000, 16'h0000, 32'd0, 1'b0, 16'd0));
		offer_tick(tick(6'b111111, 16'h0000, 32'd20, 1'b0, 16'd0));
		offer_tick(tick(6'b100000, 16'h0000, 32'd40, 1'b1, 16'd0));
		offer_tick(tick(6'b100000, 16'h0000, 32'd140, 1'b1, 16'd0));
		offer_tick(tick(6'b100000, 16'h0000, 32'd480, 1'b1, 16'd0));
		offer_tick(tick(6'b100000, 16'h0000, 32'd500, 1'b1, 16'hFFFF));
		offer_tick(tick(6'b010000, 16'h0000, 32'd520, 1'b0, 16'd0));
		offer_tick(tick(6'b010000, 16'h0000, 32'd900, 1'b1, 16'd0));
		offer_tick(tick(6'b001000, 16'h0000, 32'd920, 1'b0, 16'd0));
		offer_tick(tick(6'b001000, 16'h0000, 32'd1300, 1'b1, 16'd0));
		offer_tick(tick(6'b000100, 16'h0000, 32'd1320, 1'b0, 16'd0));
		offer_tick(tick(6'b000100, 16'h0000, 32'd1700, 1'b1, 16'hFFFF));
		offer_tick(tick(6'b000010, 16'h0000, 32'd1720, 1'b0, 16'd0));
		offer_tick(tick(6'b000010, 16'h0000, 32'd2100, 1'b1, 16'd0));
		offer_tick(tick(6'b000001, 16'h0000, 32'd2120, 1'b0, 16'd0));
		offer_tick(tick(6'b000001, 16'h0000, 32'd2500, 1'b1, 16'd0));
		// no flag after a fall in progress keeps it
		offer_tick(tick(6'b000000, 16'h0000, 32'd2520, 1'b1, 16'd0));
		offer_tick(tick(6'b100000, 16'h7FFF, 32'd2540, 1'b0, 16'd0));
		offer_tick(tick(6'b100000, 16'h8000, 32'd2560, 1'b0, 16'd0));
		offer_tick(tick(6'b000100, 16'h0000, 32'hFFFF_FFF0, 1'b0, 16'd0));
		// accel equal to threshold does not force; hold time wraps
		offer_tick(tick(6'b000100, 16'h0900, 32'h0000_0100, 1'b1, 16'd0));
		offer_tick(tick(6'b000000, 16'h0000, 32'hFFFF_FFFF, 1'b1, 16'd2000));
		offer_tick(tick(6'b000000, 16'h0901, 32'h0000_0000, 1'b1, 16'd2001));

		// Random phases, each under its own register setting
		for (int p = 0; p < 6; p++) begin
			drain_reports();
			case (p)
				0: load_limits(ACCEL_THRESHOLD_RST, SETTLE_MS_RST, RECOVER_MS_RST,
					MODE_SWAP_MS_RST);
				1: load_limits(16'h8000, 16'd0, 16'd0, 16'd0);
				2: load_limits(16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				5: load_limits(16'($urandom), 16'($urandom_range(0, 40)),
					16'($urandom_range(0, 100)), 16'($urandom));
				default: load_limits(16'($urandom_range(0, 6000)) - 16'd3000,
					16'($urandom_range(0, 200)), 16'($urandom_range(0, 600)),
					16'($urandom_range(0, 4000)));
			endcase
			clock_ms = (p % 2) ? 32'hFFFF_F800 + 32'($urandom_range(0, 255)) : $urandom;
			quiet = (p == 0);
			// long receiver stall while requests keep coming
			if (p == 3) out_hold = 150;
			run_falls(320);
			quiet = 1'b0;
		end

		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("fall_posture_debounce_recovery_test: PASS");
		else
			$display("fall_posture_debounce_recovery_test: FAIL");
		$finish;
	end

endmodule

// File: fall_posture_debounce_recovery.f
rtl/fpdr_pkg.sv
rtl/fall_posture_debounce_recovery.sv
verif/fall_posture_debounce_recovery_test.sv
